/* hdl/mre_pkg.sv */
package mre_pkg;

   localparam int DataWidth = 32;
   localparam int IndexWidth = 5;
   localparam int OpWidth = 7;

   // Operation codes (funct field, plus the host load).
   localparam logic [OpWidth-1:0] OpSll = 7'd0;
   localparam logic [OpWidth-1:0] OpSrl = 7'd2;
   localparam logic [OpWidth-1:0] OpJr = 7'd8;
   localparam logic [OpWidth-1:0] OpJalr = 7'd9;
   localparam logic [OpWidth-1:0] OpSyscall = 7'd12;
   localparam logic [OpWidth-1:0] OpMfhi = 7'd16;
   localparam logic [OpWidth-1:0] OpMflo = 7'd18;
   localparam logic [OpWidth-1:0] OpMult = 7'd24;
   localparam logic [OpWidth-1:0] OpMultu = 7'd25;
   localparam logic [OpWidth-1:0] OpDiv = 7'd26;
   localparam logic [OpWidth-1:0] OpDivu = 7'd27;
   localparam logic [OpWidth-1:0] OpAdd = 7'd32;
   localparam logic [OpWidth-1:0] OpAddu = 7'd33;
   localparam logic [OpWidth-1:0] OpSub = 7'd34;
   localparam logic [OpWidth-1:0] OpSubu = 7'd35;
   localparam logic [OpWidth-1:0] OpAnd = 7'd36;
   localparam logic [OpWidth-1:0] OpOr = 7'd37;
   localparam logic [OpWidth-1:0] OpXor = 7'd38;
   localparam logic [OpWidth-1:0] OpNor = 7'd39;
   localparam logic [OpWidth-1:0] OpSlt = 7'd42;
   localparam logic [OpWidth-1:0] OpSltu = 7'd43;
   localparam logic [OpWidth-1:0] OpHostLoad = 7'd64;

   localparam logic [IndexWidth-1:0] SyscallReg = 5'd2;
   localparam logic [DataWidth-1:0] ExitCode = 32'd10;
   localparam logic [DataWidth-1:0] LinkOffset = 32'd4;

   // Control between the sequencer and the divider.
   typedef struct packed {
      logic start;
      logic is_signed;
   } div_ctrl_type;

   typedef struct packed {
      logic done;
      logic busy;
   } div_stat_type;

endpackage

/* hdl/mips_r_type_execute_unit.sv */
// Channel   | Direction | Handshake            | Payload
// request   | in        | req_valid/req_ready  | operation, indices, shamt, pc, host data
// response  | out       | rsp_valid/rsp_ready  | destination write, jump, status flags
//
// One request at a time: rs, rt and register 2 are read in turn through the
// single read port of the RAM (the first in the accepting cycle), then the
// execute state loads the response register; mult goes on through StMulLo
// and StMulHi for the split 32x32 product, and div/divu wait for the
// bit-serial divider. Reset clears the register file with a sweep over every
// register, during which no request is taken. A stalled response holds in its
// register; the next request is taken as soon as that register is free.
module mips_r_type_execute_unit #(
   parameter int REGISTER_COUNT = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [6:0]  req_operation,
   input  logic [4:0]  req_source_a_index,
   input  logic [4:0]  req_source_b_index,
   input  logic [4:0]  req_dest_index,
   input  logic [4:0]  req_shift_amount,
   input  logic [31:0] req_current_pc,
   input  logic [31:0] req_host_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_dest_written,
   output logic [4:0]  rsp_dest_number,
   output logic [31:0] rsp_dest_value,
   output logic        rsp_jump_taken,
   output logic [31:0] rsp_jump_target,
   output logic        rsp_overflow,
   output logic        rsp_divide_by_zero,
   output logic        rsp_halt,
   output logic        rsp_illegal
);
   import mre_pkg::*;

   localparam int IdxW = $clog2(REGISTER_COUNT);

   typedef enum logic [7:0] {
      StClear = 8'b0000_0001,
      StIdle  = 8'b0000_0010,
      StReadA = 8'b0000_0100,
      StReadB = 8'b0000_1000,
      StExec  = 8'b0001_0000,
      StMulLo = 8'b0010_0000,
      StMulHi = 8'b0100_0000,
      StDiv   = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;

   logic [6:0]      op_ff;
   logic [IdxW-1:0] rs_ff, rt_ff, rd_ff;
   logic [4:0]      sh_ff;
   logic [31:0]     pc_ff, hd_ff;
   logic [31:0]     a_ff, a_in, b_ff, b_in;
   logic [31:0]     hi_ff, hi_in, lo_ff, lo_in;
   logic [IdxW-1:0] clr_ff, clr_in;

   // Partial products of the 64-bit multiply.
   logic [31:0] pp_ll_ff, pp_lh_ff, pp_hl_ff, pp_hh_ff;
   logic [31:0] pp_ll_in, pp_lh_in, pp_hl_in, pp_hh_in;

   logic            ram_we;
   logic [IdxW-1:0] ram_waddr, ram_raddr;
   logic [31:0]     ram_wdata, ram_rdata;

   div_ctrl_type div_ctrl;
   div_stat_type div_stat;
   logic [31:0]  div_q, div_r;

   logic        out_valid_ff, out_valid_in;
   logic        o_wr_ff, o_wr_in, o_jmp_ff, o_jmp_in, o_ovf_ff, o_ovf_in;
   logic        o_dz_ff, o_dz_in, o_hlt_ff, o_hlt_in, o_ill_ff, o_ill_in;
   logic [4:0]  o_num_ff, o_num_in;
   logic [31:0] o_val_ff, o_val_in, o_tgt_ff, o_tgt_in;

   logic        wr;
   logic [31:0] val, sum, diff;
   logic [63:0] prod;
   logic        mul_signed;

   mre_ram #(.Width(32), .Depth(REGISTER_COUNT)) u_regs (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   mre_divider u_div (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (div_ctrl),
      .dividend  (a_ff),
      .divisor   (b_ff),
      .stat      (div_stat),
      .quotient  (div_q),
      .remainder (div_r)
   );

   assign req_ready = (state_ff == StIdle) && !out_valid_ff;
   assign mul_signed = (op_ff == OpMult);
   assign sum = a_ff + b_ff;
   assign diff = a_ff - b_ff;

   // Full product from unsigned partial products, with signed correction.
   always_comb begin
      prod = {pp_hh_ff, pp_ll_ff} + ({32'd0, pp_lh_ff} << 16) + ({32'd0, pp_hl_ff} << 16);
      if (mul_signed) begin
         prod[63:32] = prod[63:32] - (a_ff[31] ? b_ff : 32'd0) - (b_ff[31] ? a_ff : 32'd0);
      end
   end

   // Sequencer: clear after reset; read rs, rt and register 2 in turn, then execute.
   always_comb begin
      state_in = state_ff;
      clr_in = clr_ff;
      a_in = a_ff;
      b_in = b_ff;
      hi_in = hi_ff;
      lo_in = lo_ff;
      pp_ll_in = pp_ll_ff;
      pp_lh_in = pp_lh_ff;
      pp_hl_in = pp_hl_ff;
      pp_hh_in = pp_hh_ff;
      ram_we = 1'b0;
      ram_waddr = rd_ff;
      ram_wdata = '0;
      ram_raddr = rs_ff;
      div_ctrl = '0;
      out_valid_in = out_valid_ff && !rsp_ready;
      o_wr_in = o_wr_ff;
      o_num_in = o_num_ff;
      o_val_in = o_val_ff;
      o_jmp_in = o_jmp_ff;
      o_tgt_in = o_tgt_ff;
      o_ovf_in = o_ovf_ff;
      o_dz_in = o_dz_ff;
      o_hlt_in = o_hlt_ff;
      o_ill_in = o_ill_ff;
      wr = 1'b0;
      val = '0;
      case (state_ff)
         StClear: begin
            ram_we = 1'b1;
            ram_waddr = clr_ff;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == IdxW'(REGISTER_COUNT - 1)) begin
               state_in = StIdle;
            end
         end
         StIdle: begin
            ram_raddr = req_source_a_index[IdxW-1:0];
            if (req_valid && req_ready) begin
               state_in = StReadA;
            end
         end
         StReadA: begin
            a_in = (rs_ff == '0) ? 32'd0 : ram_rdata;
            ram_raddr = rt_ff;
            state_in = StReadB;
         end
         StReadB: begin
            b_in = (rt_ff == '0) ? 32'd0 : ram_rdata;
            ram_raddr = IdxW'(SyscallReg);
            state_in = StExec;
         end
         StExec: begin
            pp_ll_in = a_ff[15:0] * b_ff[15:0];
            pp_lh_in = a_ff[15:0] * b_ff[31:16];
            pp_hl_in = a_ff[31:16] * b_ff[15:0];
            pp_hh_in = a_ff[31:16] * b_ff[31:16];
            o_wr_in = 1'b0;
            o_jmp_in = 1'b0;
            o_tgt_in = '0;
            o_ovf_in = 1'b0;
            o_dz_in = 1'b0;
            o_hlt_in = 1'b0;
            o_ill_in = 1'b0;
            state_in = StIdle;
            case (op_ff)
               OpSll: begin wr = 1'b1; val = b_ff << sh_ff; end
               OpSrl: begin wr = 1'b1; val = b_ff >> sh_ff; end
               OpJr: begin o_jmp_in = 1'b1; o_tgt_in = a_ff; end
               OpJalr: begin
                  o_jmp_in = 1'b1;
                  o_tgt_in = a_ff;
                  wr = 1'b1;
                  val = pc_ff + LinkOffset;
               end
               OpSyscall: begin
                  o_hlt_in = (ram_rdata == ExitCode);
                  o_ill_in = (ram_rdata != ExitCode);
               end
               OpMfhi: begin wr = 1'b1; val = hi_ff; end
               OpMflo: begin wr = 1'b1; val = lo_ff; end
               OpMult, OpMultu: state_in = StMulLo;
               OpDiv, OpDivu: begin
                  if (b_ff == '0) begin
                     o_dz_in = 1'b1;
                  end else begin
                     div_ctrl.start = 1'b1;
                     div_ctrl.is_signed = (op_ff == OpDiv);
                     state_in = StDiv;
                  end
               end
               OpAdd, OpAddu: begin
                  wr = 1'b1;
                  val = sum;
                  o_ovf_in = (op_ff == OpAdd) && (a_ff[31] == b_ff[31])
                             && (sum[31] != a_ff[31]);
               end
               OpSub, OpSubu: begin
                  wr = 1'b1;
                  val = diff;
                  o_ovf_in = (op_ff == OpSub) && (a_ff[31] != b_ff[31])
                             && (diff[31] != a_ff[31]);
               end
               OpAnd: begin wr = 1'b1; val = a_ff & b_ff; end
               OpOr: begin wr = 1'b1; val = a_ff | b_ff; end
               OpXor: begin wr = 1'b1; val = a_ff ^ b_ff; end
               OpNor: begin wr = 1'b1; val = ~(a_ff | b_ff); end
               OpSlt: begin wr = 1'b1; val = {31'd0, $signed(a_ff) < $signed(b_ff)}; end
               OpSltu: begin wr = 1'b1; val = {31'd0, a_ff < b_ff}; end
               OpHostLoad: begin wr = 1'b1; val = hd_ff; end
               default: o_ill_in = 1'b1;
            endcase
            wr = wr && (rd_ff != '0);
            ram_we = wr;
            ram_wdata = val;
            o_wr_in = wr;
            o_num_in = wr ? 5'(rd_ff) : 5'd0;
            o_val_in = wr ? val : 32'd0;
            if (state_in == StIdle) begin
               out_valid_in = 1'b1;
            end
         end
         StMulLo: state_in = StMulHi;
         StMulHi: begin
            hi_in = prod[63:32];
            lo_in = prod[31:0];
            out_valid_in = 1'b1;
            state_in = StIdle;
         end
         StDiv: begin
            if (div_stat.done) begin
               hi_in = div_r;
               lo_in = div_q;
               out_valid_in = 1'b1;
               state_in = StIdle;
            end
         end
         default: state_in = StIdle;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= StClear;
         clr_ff <= '0;
         out_valid_ff <= 1'b0;
         hi_ff <= '0;
         lo_ff <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         out_valid_ff <= out_valid_in;
         hi_ff <= hi_in;
         lo_ff <= lo_in;
      end
      if (req_valid && req_ready) begin
         op_ff <= req_operation;
         rs_ff <= req_source_a_index[IdxW-1:0];
         rt_ff <= req_source_b_index[IdxW-1:0];
         rd_ff <= req_dest_index[IdxW-1:0];
         sh_ff <= req_shift_amount;
         pc_ff <= req_current_pc;
         hd_ff <= req_host_data;
      end
      a_ff <= a_in;
      b_ff <= b_in;
      pp_ll_ff <= pp_ll_in;
      pp_lh_ff <= pp_lh_in;
      pp_hl_ff <= pp_hl_in;
      pp_hh_ff <= pp_hh_in;
      o_wr_ff <= o_wr_in;
      o_num_ff <= o_num_in;
      o_val_ff <= o_val_in;
      o_jmp_ff <= o_jmp_in;
      o_tgt_ff <= o_tgt_in;
      o_ovf_ff <= o_ovf_in;
      o_dz_ff <= o_dz_in;
      o_hlt_ff <= o_hlt_in;
      o_ill_ff <= o_ill_in;
   end

   // Response register outputs.
   assign rsp_valid = out_valid_ff;
   assign rsp_dest_written = o_wr_ff;
   assign rsp_dest_number = o_num_ff;
   assign rsp_dest_value = o_val_ff;
   assign rsp_jump_taken = o_jmp_ff;
   assign rsp_jump_target = o_tgt_ff;
   assign rsp_overflow = o_ovf_ff;
   assign rsp_divide_by_zero = o_dz_ff;
   assign rsp_halt = o_hlt_ff;
   assign rsp_illegal = o_ill_ff;

endmodule

/* hdl/mre_ram.sv */
module mre_ram #(
   parameter int Width = 32,
   parameter int Depth = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem [Depth];

   // Single write port, registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

/* hdl/mre_divider.sv */
module mre_divider (
   input  logic                  clock,
   input  logic                  reset,
   input  mre_pkg::div_ctrl_type ctrl,
   input  logic [31:0]           dividend,
   input  logic [31:0]           divisor,
   output mre_pkg::div_stat_type stat,
   output logic [31:0]           quotient,
   output logic [31:0]           remainder
);
   import mre_pkg::*;

   logic [31:0] quo_ff, quo_in;
   logic [32:0] rem_ff, rem_in;
   logic [31:0] dvs_ff, dvs_in;
   logic        neg_q_ff, neg_q_in, neg_r_ff, neg_r_in;
   logic [5:0]  count_ff, count_in;
   logic        busy_ff, busy_in, done_ff, done_in;
   logic [32:0] trial;

   // Restoring division, one quotient bit per cycle on magnitudes.
   always_comb begin
      trial = {rem_ff[31:0], quo_ff[31]} - {1'b0, dvs_ff};
      quo_in = quo_ff;
      rem_in = rem_ff;
      dvs_in = dvs_ff;
      neg_q_in = neg_q_ff;
      neg_r_in = neg_r_ff;
      count_in = count_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (ctrl.start) begin
         neg_r_in = ctrl.is_signed & dividend[31];
         neg_q_in = ctrl.is_signed & (dividend[31] ^ divisor[31]);
         quo_in = (ctrl.is_signed & dividend[31]) ? 32'd0 - dividend : dividend;
         dvs_in = (ctrl.is_signed & divisor[31]) ? 32'd0 - divisor : divisor;
         rem_in = '0;
         count_in = 6'd32;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[32]) begin
            rem_in = trial;
            quo_in = {quo_ff[30:0], 1'b1};
         end else begin
            rem_in = {rem_ff[31:0], quo_ff[31]};
            quo_in = {quo_ff[30:0], 1'b0};
         end
         count_in = count_ff - 6'd1;
         if (count_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         count_ff <= count_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      neg_q_ff <= neg_q_in;
      neg_r_ff <= neg_r_in;
   end

   // Sign correction of the finished magnitudes.
   assign quotient = neg_q_ff ? 32'd0 - quo_ff : quo_ff;
   assign remainder = neg_r_ff ? 32'd0 - rem_ff[31:0] : rem_ff[31:0];
   assign stat.done = done_ff;
   assign stat.busy = busy_ff;

endmodule
